// File: rtl/core/lbc_pkg.sv
// Shared constants, codes and types of the line break cache.
package lbc_pkg;

  localparam int unsigned Entries   = 256;
  localparam int unsigned MaxBreaks = 16;
  localparam int unsigned EntW      = $clog2(Entries);
  localparam int unsigned UsedW     = $clog2(Entries + 1);
  localparam int unsigned BrkIdxW   = $clog2(MaxBreaks);
  localparam int unsigned BrkAddrW  = $clog2(Entries * MaxBreaks);
  localparam int unsigned CntW      = 5;
  localparam int unsigned KeyW      = 20;
  localparam int unsigned WidW      = 10;
  localparam int unsigned BrkW      = 16;
  localparam int unsigned RateW     = 7;
  localparam int unsigned MetaW     = KeyW + WidW + CntW;

  typedef enum logic [2:0] {
    KIND_LOOKUP  = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_BREAK   = 3'd2,
    KIND_INV_ONE = 3'd3,
    KIND_INV_ALL = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADCOUNT = 3'd3,
    ST_NOSTORE  = 3'd4
  } status_e;

  // Command from the sequencer to the divider, and its answer.
  typedef struct packed {
    logic        start;
    logic [31:0] hits;
    logic [31:0] misses;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [RateW-1:0] pct;
  } div_rsp_t;

endpackage

// File: rtl/core/lbc_ram.sv
// Generic single-port RAM with registered read.
module lbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/core/lbc_div.sv
// Restoring divider computing hits*100/(hits+misses), one quotient bit a cycle.
module lbc_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lbc_pkg::div_req_t req_i,
  output lbc_pkg::div_rsp_t rsp_o
);
  import lbc_pkg::*;

  logic [39:0]      num_q, num_d;
  logic [32:0]      den_q, den_d;
  logic [32:0]      rem_q, rem_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  // The quotient never exceeds 100, so only its low bits are kept.
  logic [RateW-1:0] quo_q, quo_d;
  logic [33:0]      trial;
  logic [32:0]      total;

  assign total = {1'b0, req_i.hits} + {1'b0, req_i.misses};
  assign trial = {rem_q, num_q[39]};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      // hits*100 as (hits<<6)+(hits<<5)+(hits<<2), below 2^39.
      num_d  = {2'b0, req_i.hits, 6'b0} + {3'b0, req_i.hits, 5'b0} +
               {6'b0, req_i.hits, 2'b0};
      den_d  = total;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'd40;
      busy_d = (total != '0);
    end else if (busy_q) begin
      num_d = {num_q[38:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = 33'(trial - {1'b0, den_q});
        quo_d = {quo_q[RateW-2:0], 1'b1};
      end else begin
        rem_d = trial[32:0];
        quo_d = {quo_q[RateW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      quo_q  <= quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.pct  = quo_q;
endmodule

// File: rtl/core/line_break_cache_top.sv
// Top level of the line break cache: scan sequencer, tables and output word.
//
// Usage: one input word on s_axis (kind, line id, width, cap, count, break
// value) causes one or more result words on m_axis. A lookup hit returns
// min(count, cap) break positions, one word each, the final one with tlast;
// every other case returns a single word with a status in tuser.
// Sequence: a lookup, a store header or a line invalidation scans the used
// slots one per cycle through the metadata RAM; invalidate-all sweeps the
// valid bits of the used slots. The hit rate is then recomputed by a
// bit-serial divider: a load, 40 quotient bits and a hand-off. A hit then
// reads each of its break positions from the break RAM before its word.
// s_axis_tready is low until the last result word of an item is taken, so
// one item is handled at a time.
// Reset clears the counters, the slot count, the open store and all valid
// bits; RAM contents stay undefined, and metadata is read only once written.
// When the receiver stalls, the output word holds in its register and the
// sequencer waits; nothing is lost.
module line_break_cache_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: line_id[19:0], width[29:20], cap[34:30], count[39:35],
  // break_in[55:40]
  input  logic [55:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: break_out[15:0], returned[20:16], hit_rate_pct[27:21], zero fill
  output logic [31:0] m_axis_tdata,
  // tuser: status[2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import lbc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_SWEEP  = 8'b0000_0100,
    S_HIT    = 8'b0000_1000,
    S_BRK    = 8'b0001_0000,
    S_RATE   = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_WAIT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]        kind_q;
  logic [KeyW-1:0]   key_q;
  logic [WidW-1:0]   wid_q;
  logic [CntW-1:0]   cap_q, cnt_q;
  logic [BrkW-1:0]   brk_q;

  logic [UsedW-1:0]  used_q;
  logic [31:0]       hits_q, misses_q;
  logic [EntW-1:0]   open_ent_q;
  logic [CntW-1:0]   open_rem_q;
  // Break count of the slot whose store is open.
  logic [CntW-1:0]   open_cnt_q;
  logic [Entries-1:0] valid_q;

  // Scan: idx_q is the address presented, cmp_q the slot whose data is out.
  logic [UsedW-1:0]  idx_q;
  logic              cmp_v_q;
  logic [EntW-1:0]   cmp_q;
  logic [EntW-1:0]   slot_q;
  logic [CntW-1:0]   k_q, j_q;

  logic              meta_we;
  logic [EntW-1:0]   meta_addr;
  logic [MetaW-1:0]  meta_wdata, meta_rdata;
  logic              brk_we;
  logic [BrkAddrW-1:0] brk_addr;
  logic [BrkW-1:0]   brk_rdata;

  logic [KeyW-1:0]   r_key;
  logic [WidW-1:0]   r_wid;
  logic [CntW-1:0]   r_cnt;
  assign {r_key, r_wid, r_cnt} = meta_rdata;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [2:0]       o_st_q;
  logic [BrkW-1:0]  o_brk_q;
  logic [CntW-1:0]  o_ret_q;
  logic             o_last_q;
  logic             out_v_q;
  logic [RateW-1:0] o_pct_q;
  logic             rate_go_q;
  logic             rate_known_q;

  lbc_ram #(.Width(MetaW), .Depth(Entries)) u_meta (
    .clk_i, .we_i(meta_we), .addr_i(meta_addr), .wdata_i(meta_wdata),
    .rdata_o(meta_rdata)
  );

  lbc_ram #(.Width(BrkW), .Depth(Entries * MaxBreaks)) u_brk (
    .clk_i, .we_i(brk_we), .addr_i(brk_addr), .wdata_i(brk_q),
    .rdata_o(brk_rdata)
  );

  lbc_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic scan_done;
  assign scan_done = (idx_q >= used_q);

  logic match;
  always_comb begin
    match = 1'b0;
    if (cmp_v_q) begin
      if (kind_q == KIND_LOOKUP) begin
        match = valid_q[cmp_q] && r_key == key_q && r_wid == wid_q;
      end else begin
        match = (r_key == key_q);
      end
    end
  end

  logic [CntW-1:0] kmin;
  assign kmin = (r_cnt < cap_q) ? r_cnt : cap_q;

  assign s_axis_tready = (state_q == S_IDLE);
  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // A lookup hit with breaks to return.
  function automatic logic hit_pending();
    return (kind_q == KIND_LOOKUP) && (o_st_q == ST_OK) && (k_q != '0) &&
           (state_q != S_IDLE);
  endfunction

  function automatic logic hit_rate_known();
    return rate_known_q;
  endfunction

  always_comb begin
    meta_we    = 1'b0;
    meta_addr  = idx_q[EntW-1:0];
    meta_wdata = {key_q, wid_q, cnt_q};
    brk_we     = 1'b0;
    brk_addr   = {slot_q, j_q[BrkIdxW-1:0]};
    if (state_q == S_BRK) begin
      brk_we   = 1'b1;
      brk_addr = {open_ent_q,
                  BrkIdxW'(open_cnt_q - open_rem_q)};
    end
    if (state_q == S_SCAN && kind_q == KIND_HEADER && (match ||
        (scan_done && !cmp_v_q)) && !(scan_done && !cmp_v_q && !match &&
        used_q >= UsedW'(Entries))) begin
      meta_we   = 1'b1;
      meta_addr = match ? cmp_q : used_q[EntW-1:0];
    end
  end

  assign dreq.hits   = hits_q;
  assign dreq.misses = misses_q;
  assign dreq.start  = rate_go_q;

  // Result words are first built, then the rate is appended before emission.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      hits_q     <= '0;
      misses_q   <= '0;
      open_ent_q <= '0;
      open_rem_q <= '0;
      open_cnt_q <= '0;
      valid_q    <= '0;
      out_v_q    <= 1'b0;
      rate_go_q  <= 1'b0;
      idx_q      <= '0;
      cmp_v_q    <= 1'b0;
      o_pct_q    <= '0;
    end else begin
      if (out_v_q && m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            idx_q   <= '0;
            cmp_v_q <= 1'b0;
            k_q     <= '0;
            o_brk_q <= '0;
            o_ret_q <= '0;
            o_last_q <= 1'b1;
            o_st_q  <= ST_OK;
            case (kind_e'(s_axis_tuser))
              KIND_LOOKUP: state_q <= S_SCAN;
              KIND_HEADER: begin
                open_rem_q <= '0;
                if (s_axis_tdata[39:35] > CntW'(MaxBreaks)) begin
                  o_st_q    <= ST_BADCOUNT;
                  rate_go_q <= 1'b1;
                  state_q   <= S_RATE;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              KIND_BREAK: begin
                if (open_rem_q == '0) begin
                  o_st_q    <= ST_NOSTORE;
                  rate_go_q <= 1'b1;
                  state_q   <= S_RATE;
                end else begin
                  state_q <= S_BRK;
                end
              end
              KIND_INV_ONE: state_q <= S_SCAN;
              KIND_INV_ALL: state_q <= S_SWEEP;
              default: begin
                rate_go_q <= 1'b1;
                state_q   <= S_RATE;
              end
            endcase
          end
        end
        S_SCAN: begin
          cmp_v_q <= !scan_done;
          cmp_q   <= idx_q[EntW-1:0];
          if (!scan_done) begin
            idx_q <= idx_q + UsedW'(1);
          end
          if (kind_q == KIND_INV_ONE) begin
            if (match) begin
              valid_q[cmp_q] <= 1'b0;
            end
            if (scan_done && !cmp_v_q) begin
              rate_go_q <= 1'b1;
              state_q   <= S_RATE;
            end
          end else if (match) begin
            if (kind_q == KIND_LOOKUP) begin
              if (hits_q != '1) hits_q <= hits_q + 32'd1;
              slot_q <= cmp_q;
              k_q    <= kmin;
              j_q    <= '0;
              if (kmin == '0) begin
                rate_go_q <= 1'b1;
                state_q   <= S_RATE;
              end else begin
                state_q <= S_HIT;
              end
            end else begin
              valid_q[cmp_q] <= 1'b1;
              open_ent_q     <= cmp_q;
              open_rem_q     <= cnt_q;
              open_cnt_q     <= cnt_q;
              rate_go_q      <= 1'b1;
              state_q        <= S_RATE;
            end
          end else if (scan_done && !cmp_v_q) begin
            if (kind_q == KIND_LOOKUP) begin
              if (misses_q != '1) misses_q <= misses_q + 32'd1;
              o_st_q <= ST_MISS;
            end else if (used_q >= UsedW'(Entries)) begin
              o_st_q <= ST_FULL;
            end else begin
              valid_q[used_q[EntW-1:0]] <= 1'b1;
              open_ent_q <= used_q[EntW-1:0];
              open_rem_q <= cnt_q;
              open_cnt_q <= cnt_q;
              used_q     <= used_q + UsedW'(1);
            end
            rate_go_q <= 1'b1;
            state_q   <= S_RATE;
          end
        end
        S_SWEEP: begin
          if (scan_done) begin
            rate_go_q <= 1'b1;
            state_q   <= S_RATE;
          end else begin
            valid_q[idx_q[EntW-1:0]] <= 1'b0;
            idx_q <= idx_q + UsedW'(1);
          end
        end
        S_BRK: begin
          open_rem_q <= open_rem_q - CntW'(1);
          rate_go_q  <= 1'b1;
          state_q    <= S_RATE;
        end
        S_RATE: begin
          // The first cycle here starts the divider.
          if (rate_go_q) begin
            rate_go_q <= 1'b0;
          end else if (!drsp.busy) begin
            o_pct_q <= (hits_q == '0) ? '0 : drsp.pct;
            if (kind_q == KIND_LOOKUP && o_st_q == ST_OK && k_q != '0 &&
                hit_pending()) begin
              state_q <= S_WAIT;
            end else begin
              out_v_q <= 1'b1;
              state_q <= S_EMIT;
            end
          end
        end
        S_WAIT: begin
          // Break RAM address j_q was presented last cycle.
          o_brk_q  <= brk_rdata;
          o_ret_q  <= k_q;
          o_last_q <= (j_q + CntW'(1) == k_q);
          out_v_q  <= 1'b1;
          state_q  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_v_q && m_axis_tready) begin
            if (hit_pending() && !o_last_q) begin
              j_q     <= j_q + CntW'(1);
              state_q <= S_HIT;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_HIT: begin
          if (j_q == '0 && !hit_rate_known()) begin
            rate_go_q <= 1'b1;
            state_q   <= S_RATE;
          end else begin
            state_q <= S_WAIT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_known_q <= 1'b0;
    end else if (in_acc) begin
      rate_known_q <= 1'b0;
    end else if (state_q == S_RATE) begin
      rate_known_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[19:0];
      wid_q  <= s_axis_tdata[29:20];
      cap_q  <= s_axis_tdata[34:30];
      cnt_q  <= s_axis_tdata[39:35];
      brk_q  <= s_axis_tdata[55:40];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {4'b0, o_pct_q, o_ret_q, o_brk_q};
  assign m_axis_tuser  = o_st_q;
  assign m_axis_tlast  = o_last_q;
endmodule

// File: rtl/core/lbc_checker.sv
// Port-level checker for the line break cache, bound to the top level.
module lbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import lbc_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while a result is pending");

  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[27:21] <= 7'd100)
    else $error("hit rate above 100");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast)
    else $error("status result without last mark");
endmodule

bind line_break_cache_top lbc_checker u_lbc_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
);

// File: test/tb_top.sv
// Self-checking testbench of the line break cache: directed table, random traffic, table fill.
`timescale 1ns / 100ps

module tb_top;
  import lbc_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned RandItems  = 24;

  typedef struct {
    status_e    st;
    logic [15:0] brk;
    logic [4:0]  ret;
    logic        last;
    logic [6:0]  pct;
  } word_t;

  typedef struct {
    logic [2:0]  kind;
    logic [19:0] line;
    logic [9:0]  wid;
    logic [4:0]  cap;
    logic [4:0]  cnt;
    logic [15:0] brk;
    bit          typed;
    status_e     st;
    logic [6:0]  pct;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  line_break_cache_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the cache table and counters.
  logic [19:0] slot_key [Entries];
  logic [9:0]  slot_width [Entries];
  logic [4:0]  slot_count [Entries];
  bit          slot_valid [Entries];
  logic [15:0] slot_brk [Entries][MaxBreaks];
  bit          brk_known [Entries][MaxBreaks];
  int unsigned slots_used = 0;
  logic [31:0] hits = 0;
  logic [31:0] misses = 0;
  int unsigned open_slot = 0;
  int unsigned open_left = 0;

  word_t pending_words[$];
  int    errs = 0;
  int    n_items = 0;
  int    n_words = 0;
  int    n_hit_words = 0;
  bit    quiet = 1'b0;
  row_t  dir_rows[$];

  function automatic logic [6:0] hit_pct();
    logic [63:0] total;
    total = 64'(hits) + 64'(misses);
    if (total == 0) return '0;
    return 7'((64'(hits) * 100) / total);
  endfunction

  function automatic void push_word(ref word_t res[$], input status_e st,
                                    input logic [15:0] brk, input logic [4:0] ret,
                                    input logic last);
    word_t w;
    w.st = st; w.brk = brk; w.ret = ret; w.last = last; w.pct = hit_pct();
    res.push_back(w);
  endfunction

  function automatic int find_hit(logic [19:0] line, logic [9:0] wid);
    for (int i = 0; i < slots_used; i++)
      if (slot_valid[i] && slot_key[i] == line && slot_width[i] == wid) return i;
    return -1;
  endfunction

  // Lowers the cap so that a hit never returns a break position not yet written.
  function automatic logic [4:0] safe_cap(logic [19:0] line, logic [9:0] wid,
                                          logic [4:0] cap);
    int s;
    int k;
    int w;
    s = find_hit(line, wid);
    if (s < 0) return cap;
    k = (slot_count[s] < cap) ? slot_count[s] : cap;
    w = 0;
    while (w < MaxBreaks && brk_known[s][w]) w++;
    return (k > w) ? 5'(w) : cap;
  endfunction

  function automatic void cache_predict(row_t r, ref word_t res[$]);
    int s;
    int k;
    case (r.kind)
      KIND_LOOKUP: begin
        s = find_hit(r.line, r.wid);
        if (s < 0) begin
          if (misses != '1) misses++;
          push_word(res, ST_MISS, '0, '0, 1'b1);
        end else begin
          k = (slot_count[s] < r.cap) ? slot_count[s] : r.cap;
          if (k > MaxBreaks) k = MaxBreaks;
          if (hits != '1) hits++;
          if (k == 0) push_word(res, ST_OK, '0, '0, 1'b1);
          for (int j = 0; j < k; j++)
            push_word(res, ST_OK, slot_brk[s][j], 5'(k), j + 1 == k);
        end
      end
      KIND_HEADER: begin
        open_left = 0;
        s = -1;
        if (r.cnt > MaxBreaks) begin
          push_word(res, ST_BADCOUNT, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < slots_used && s < 0; i++)
            if (slot_key[i] == r.line) s = i;
          if (s < 0 && slots_used >= Entries) begin
            push_word(res, ST_FULL, '0, '0, 1'b1);
          end else begin
            if (s < 0) s = slots_used++;
            slot_key[s] = r.line;
            slot_width[s] = r.wid;
            slot_count[s] = r.cnt;
            slot_valid[s] = 1'b1;
            open_slot = s;
            open_left = r.cnt;
            push_word(res, ST_OK, '0, '0, 1'b1);
          end
        end
      end
      KIND_BREAK: begin
        if (open_left == 0 || open_left > slot_count[open_slot]) begin
          open_left = 0;
          push_word(res, ST_NOSTORE, '0, '0, 1'b1);
        end else begin
          k = slot_count[open_slot] - open_left;
          slot_brk[open_slot][k] = r.brk;
          brk_known[open_slot][k] = 1'b1;
          open_left--;
          push_word(res, ST_OK, '0, '0, 1'b1);
        end
      end
      KIND_INV_ONE: begin
        for (int i = 0; i < slots_used; i++)
          if (slot_key[i] == r.line) slot_valid[i] = 1'b0;
        push_word(res, ST_OK, '0, '0, 1'b1);
      end
      KIND_INV_ALL: begin
        for (int i = 0; i < slots_used; i++) slot_valid[i] = 1'b0;
        push_word(res, ST_OK, '0, '0, 1'b1);
      end
      default: push_word(res, ST_OK, '0, '0, 1'b1);
    endcase
  endfunction

  // Drives one input word, waits for its handshake and queues its results.
  task automatic send_item(row_t r);
    word_t res[$];
    word_t w;
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    if (r.kind == KIND_LOOKUP) r.cap = safe_cap(r.line, r.wid, r.cap);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {r.brk, r.cnt, r.cap, r.wid, r.line};
    do @(posedge clk_i); while (!s_axis_tready);
    cache_predict(r, res);
    if (r.typed) begin
      w.st = r.st; w.brk = '0; w.ret = '0; w.last = 1'b1; w.pct = r.pct;
      pending_words.push_back(w);
    end else begin
      foreach (res[i]) pending_words.push_back(res[i]);
    end
    n_items++;
  endtask

  function automatic row_t mk(logic [2:0] kind, logic [19:0] line, logic [9:0] wid,
                              logic [4:0] cap, logic [4:0] cnt, logic [15:0] brk);
    row_t r;
    r.kind = kind; r.line = line; r.wid = wid; r.cap = cap; r.cnt = cnt; r.brk = brk;
    r.typed = 1'b0; r.st = ST_OK; r.pct = '0;
    return r;
  endfunction

  function automatic row_t typed_row(row_t r, status_e st, logic [6:0] pct);
    r.typed = 1'b1; r.st = st; r.pct = pct;
    return r;
  endfunction

  always @(negedge clk_i)
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 22);

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk_i) begin
    word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_words++;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected, tdata %h", m_axis_tdata);
        errs++;
      end else begin
        w = pending_words.pop_front();
        if (w.ret != 0) n_hit_words++;
        check_field("status", w.st, m_axis_tuser);
        check_field("break_out", w.brk, m_axis_tdata[15:0]);
        check_field("returned", w.ret, m_axis_tdata[20:16]);
        check_field("hit_rate_pct", w.pct, m_axis_tdata[27:21]);
        check_field("last", w.last, m_axis_tlast);
      end
    end
  end

  int unsigned stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else if (rst_ni) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [19:0] keys [6];
    logic [9:0]  wids [4];
    logic [4:0]  cnt;
    int          nb;
    int          items0;
    keys = '{20'h00005, 20'hFFFFF, 20'h00000, 20'hA5A5A, 20'h5A5A5, 20'h00007};
    wids = '{10'd0, 10'd80, 10'd1023, 10'd341};

    // Directed rows: errors and first results typed, hits left to the predictor.
    dir_rows.push_back(typed_row(mk(KIND_LOOKUP, 0, 0, 16, 0, 0), ST_MISS, 0));
    dir_rows.push_back(typed_row(mk(KIND_BREAK, 0, 0, 0, 0, 16'hFFFF), ST_NOSTORE, 0));
    dir_rows.push_back(typed_row(mk(KIND_HEADER, 5, 80, 0, 17, 0), ST_BADCOUNT, 0));
    dir_rows.push_back(typed_row(mk(KIND_HEADER, 20'hFFFFF, 1023, 31, 31, 0),
                                 ST_BADCOUNT, 0));
    dir_rows.push_back(typed_row(mk(KIND_HEADER, 5, 80, 0, 3, 0), ST_OK, 0));
    dir_rows.push_back(mk(KIND_BREAK, 0, 0, 0, 0, 16'h0000));
    dir_rows.push_back(mk(KIND_BREAK, 20'hFFFFF, 1023, 31, 31, 16'hFFFF));
    dir_rows.push_back(mk(KIND_BREAK, 0, 0, 0, 0, 16'h1234));
    dir_rows.push_back(typed_row(mk(KIND_BREAK, 0, 0, 0, 0, 16'h4321), ST_NOSTORE, 0));
    dir_rows.push_back(mk(KIND_LOOKUP, 5, 80, 16, 0, 0));
    dir_rows.push_back(mk(KIND_LOOKUP, 5, 81, 16, 0, 0));
    dir_rows.push_back(mk(KIND_LOOKUP, 5, 80, 0, 0, 0));
    dir_rows.push_back(mk(KIND_LOOKUP, 5, 80, 2, 0, 0));
    dir_rows.push_back(mk(KIND_HEADER, 20'hFFFFF, 1023, 0, 0, 0));
    dir_rows.push_back(mk(KIND_LOOKUP, 20'hFFFFF, 1023, 16, 0, 0));
    dir_rows.push_back(mk(KIND_BREAK, 0, 0, 0, 0, 16'h5555));
    dir_rows.push_back(mk(KIND_HEADER, 7, 10, 0, 2, 0));
    dir_rows.push_back(mk(KIND_BREAK, 0, 0, 0, 0, 16'hAAAA));
    // A new header closes the half-filled store of line 7.
    dir_rows.push_back(mk(KIND_HEADER, 5, 80, 0, 3, 0));
    dir_rows.push_back(mk(KIND_BREAK, 0, 0, 0, 0, 16'h8001));
    dir_rows.push_back(mk(KIND_INV_ONE, 5, 0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_LOOKUP, 5, 80, 16, 0, 0));
    dir_rows.push_back(mk(KIND_INV_ALL, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(KIND_LOOKUP, 20'hFFFFF, 1023, 16, 0, 0));
    dir_rows.push_back(mk(3'd5, 20'h12345, 7, 3, 3, 16'h7777));
    dir_rows.push_back(mk(3'd7, 0, 0, 0, 0, 0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // Random traffic: mostly header-plus-breaks sequences and lookups on a small key set.
    items0 = n_items;
    quiet = 1'b0;
    while (n_items - items0 < RandItems) begin
      if ($urandom_range(99) < 45) begin
        cnt = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17))
                                       : 5'($urandom_range(16));
        send_item(mk(KIND_HEADER, keys[$urandom_range(5)], wids[$urandom_range(3)],
                     5'($urandom_range(31)), cnt, 16'($urandom)));
        nb = cnt;
        if (cnt > MaxBreaks || $urandom_range(9) == 0) nb = $urandom_range(2);
        for (int j = 0; j < nb; j++)
          send_item(mk(KIND_BREAK, 20'($urandom), 10'($urandom), 5'($urandom),
                       5'($urandom), 16'($urandom)));
        repeat ($urandom_range(3, 1))
          send_item(mk(KIND_LOOKUP, keys[$urandom_range(5)], wids[$urandom_range(3)],
                       5'($urandom_range(16)), 5'($urandom), 16'($urandom)));
      end else begin
        case ($urandom_range(19))
          0, 1: send_item(mk(KIND_BREAK, 20'($urandom), 10'($urandom), 0, 0,
                             16'($urandom)));
          2, 3: send_item(mk(KIND_INV_ONE, keys[$urandom_range(5)], 10'($urandom), 0, 0,
                             0));
          4: send_item(mk(KIND_INV_ALL, 20'($urandom), 0, 0, 0, 0));
          5: send_item(mk(3'($urandom_range(7, 5)), 20'($urandom), 10'($urandom),
                          5'($urandom), 5'($urandom), 16'($urandom)));
          6, 7: send_item(mk(KIND_LOOKUP, 20'($urandom), 10'($urandom),
                             5'($urandom_range(16)), 5'($urandom), 16'($urandom)));
          default: send_item(mk(KIND_LOOKUP, keys[$urandom_range(5)],
                                wids[$urandom_range(3)], 5'($urandom_range(16)), 0, 0));
        endcase
      end
    end

    // Fill every slot with fresh keys, then one more new key finds the table full.
    // The first part of the fill runs with no idling on either side.
    for (int i = 0; slots_used < Entries; i++) begin
      quiet = (i < 80);
      send_item(mk(KIND_HEADER, 20'h80000 + 20'(i), 10'($urandom), 0, 0, 0));
    end
    quiet = 1'b0;
    send_item(mk(KIND_HEADER, 20'h7FFFF, 5, 0, 1, 0));
    send_item(mk(KIND_HEADER, keys[0], 80, 0, 0, 0));
    send_item(mk(KIND_LOOKUP, keys[0], 80, 16, 0, 0));
    send_item(mk(KIND_LOOKUP, 20'h80003, 0, 16, 0, 0));

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (400) @(posedge clk_i);

    $display("Sent %0d input words, checked %0d result words (%0d carrying breaks).",
             n_items, n_words, n_hit_words);
    $display("Table slots in use at the end: %0d.", slots_used);
    if (errs == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/lbc_pkg.sv
rtl/core/lbc_ram.sv
rtl/core/lbc_div.sv
rtl/core/line_break_cache_top.sv
rtl/core/lbc_checker.sv
test/tb_top.sv
